// ----- rtl/segint_pkg.sv -----
// Package for the segment crossing test: widths, item structs and the
// record handed along the divider cell row. No dependencies.
package segint_pkg;

  localparam int CW  = 16;          // coordinate width
  localparam int DFW = CW + 1;      // coordinate difference
  localparam int PW  = 2 * DFW;     // product of two differences
  localparam int SW  = PW + 1;      // den, num1, num2
  localparam int DW  = 2 * CW + 1;  // magnitude of den or num1
  localparam int NW  = DW + CW;     // |num1| * |delta|

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [DFW-1:0] dif_t;
  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [SW-1:0]  sum_t;
  typedef logic        [DW-1:0]  mag_t;
  typedef logic        [NW-1:0]  num_t;
  typedef logic        [CW-1:0]  quo_t;
  typedef logic signed [CW+1:0]  pos_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } in_item_t;

  typedef struct packed {
    logic   crossing_found;
    coord_t cross_x;
    coord_t cross_y;
  } out_item_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t x3;
    coord_t y3;
    coord_t x4;
    coord_t y4;
  } pts_t;

  // One item in flight through the divider row; x and y lanes share d.
  typedef struct packed {
    logic hit;
    logic negx;
    logic negy;
    mag_t d;
    mag_t rx;
    mag_t ry;
    quo_t nx;
    quo_t ny;
    quo_t qx;
    quo_t qy;
    pts_t pts;
  } dcell_t;

endpackage

// ----- rtl/segint_front.sv -----
// Front pipeline: differences, cross products, den/num terms, inside tests
// and the scaled numerators that seed the divider row. Uses segint_pkg.
module segint_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  output logic                in_rdy,
  input  segint_pkg::in_item_t in_d,
  output logic                out_vld,
  input  logic                out_rdy,
  output segint_pkg::dcell_t  out_d
);

  function automatic segint_pkg::mag_t smag(input segint_pkg::sum_t v);
    segint_pkg::sum_t a;
    a = v[segint_pkg::SW-1] ? -v : v;
    return a[segint_pkg::DW-1:0];
  endfunction

  function automatic segint_pkg::quo_t dmag(input segint_pkg::dif_t v);
    segint_pkg::dif_t a;
    a = v[segint_pkg::DFW-1] ? -v : v;
    return a[segint_pkg::CW-1:0];
  endfunction

  // stage A: differences
  logic a_vld_r, a_rdy;
  segint_pkg::pts_t a_pts_r, a_pts_nxt;
  segint_pkg::dif_t a_dx21_r, a_dy21_r, a_dx43_r, a_dy43_r, a_dx13_r, a_dy13_r;
  segint_pkg::dif_t a_dx21_nxt, a_dy21_nxt, a_dx43_nxt, a_dy43_nxt, a_dx13_nxt, a_dy13_nxt;

  // stage B: products
  logic b_vld_r, b_rdy;
  segint_pkg::pts_t  b_pts_r;
  segint_pkg::dif_t  b_dx21_r, b_dy21_r;
  segint_pkg::prod_t b_p0_r, b_p1_r, b_p2_r, b_p3_r, b_p4_r, b_p5_r;
  segint_pkg::prod_t b_p0_nxt, b_p1_nxt, b_p2_nxt, b_p3_nxt, b_p4_nxt, b_p5_nxt;

  // stage C: den, num1, num2
  logic c_vld_r, c_rdy;
  segint_pkg::pts_t c_pts_r;
  segint_pkg::dif_t c_dx21_r, c_dy21_r;
  segint_pkg::sum_t c_den_r, c_num1_r, c_num2_r;
  segint_pkg::sum_t c_den_nxt, c_num1_nxt, c_num2_nxt;

  // stage D: inside tests, magnitudes
  logic d_vld_r, d_rdy;
  segint_pkg::pts_t d_pts_r;
  logic d_hit_r, d_negx_r, d_negy_r;
  logic d_hit_nxt, d_negx_nxt, d_negy_nxt;
  segint_pkg::mag_t d_n1m_r, d_dnm_r, d_n1m_nxt, d_dnm_nxt, d_n2m;
  segint_pkg::quo_t d_dxm_r, d_dym_r;

  // stage E: scaled numerators
  logic e_vld_r, e_rdy;
  segint_pkg::dcell_t e_d_r, e_d_nxt;
  segint_pkg::num_t e_px, e_py;

  assign e_rdy  = !e_vld_r || out_rdy;
  assign d_rdy  = !d_vld_r || e_rdy;
  assign c_rdy  = !c_vld_r || d_rdy;
  assign b_rdy  = !b_vld_r || c_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign in_rdy = a_rdy;

  always_comb begin
    a_pts_nxt.x1 = in_d.first_start_x;
    a_pts_nxt.y1 = in_d.first_start_y;
    a_pts_nxt.x2 = in_d.first_end_x;
    a_pts_nxt.y2 = in_d.first_end_y;
    a_pts_nxt.x3 = in_d.second_start_x;
    a_pts_nxt.y3 = in_d.second_start_y;
    a_pts_nxt.x4 = in_d.second_end_x;
    a_pts_nxt.y4 = in_d.second_end_y;
    a_dx21_nxt = segint_pkg::dif_t'($signed(in_d.first_end_x))
               - segint_pkg::dif_t'($signed(in_d.first_start_x));
    a_dy21_nxt = segint_pkg::dif_t'($signed(in_d.first_end_y))
               - segint_pkg::dif_t'($signed(in_d.first_start_y));
    a_dx43_nxt = segint_pkg::dif_t'($signed(in_d.second_end_x))
               - segint_pkg::dif_t'($signed(in_d.second_start_x));
    a_dy43_nxt = segint_pkg::dif_t'($signed(in_d.second_end_y))
               - segint_pkg::dif_t'($signed(in_d.second_start_y));
    a_dx13_nxt = segint_pkg::dif_t'($signed(in_d.first_start_x))
               - segint_pkg::dif_t'($signed(in_d.second_start_x));
    a_dy13_nxt = segint_pkg::dif_t'($signed(in_d.first_start_y))
               - segint_pkg::dif_t'($signed(in_d.second_start_y));
  end

  always_comb begin
    b_p0_nxt = a_dy43_r * a_dx21_r;
    b_p1_nxt = a_dx43_r * a_dy21_r;
    b_p2_nxt = a_dx43_r * a_dy13_r;
    b_p3_nxt = a_dy43_r * a_dx13_r;
    b_p4_nxt = a_dx21_r * a_dy13_r;
    b_p5_nxt = a_dy21_r * a_dx13_r;
  end

  always_comb begin
    c_den_nxt  = segint_pkg::sum_t'(b_p0_r) - segint_pkg::sum_t'(b_p1_r);
    c_num1_nxt = segint_pkg::sum_t'(b_p2_r) - segint_pkg::sum_t'(b_p3_r);
    c_num2_nxt = segint_pkg::sum_t'(b_p4_r) - segint_pkg::sum_t'(b_p5_r);
  end

  always_comb begin
    d_dnm_nxt  = smag(c_den_r);
    d_n1m_nxt  = smag(c_num1_r);
    d_n2m      = smag(c_num2_r);
    d_hit_nxt  = (c_den_r != '0)
              && (c_num1_r != '0)
              && (c_num1_r[segint_pkg::SW-1] == c_den_r[segint_pkg::SW-1])
              && (d_n1m_nxt < d_dnm_nxt)
              && (c_num2_r != '0)
              && (c_num2_r[segint_pkg::SW-1] == c_den_r[segint_pkg::SW-1])
              && (d_n2m < d_dnm_nxt);
    d_negx_nxt = c_num1_r[segint_pkg::SW-1] ^ c_dx21_r[segint_pkg::DFW-1]
               ^ c_den_r[segint_pkg::SW-1];
    d_negy_nxt = c_num1_r[segint_pkg::SW-1] ^ c_dy21_r[segint_pkg::DFW-1]
               ^ c_den_r[segint_pkg::SW-1];
  end

  always_comb begin
    e_px         = segint_pkg::num_t'(d_n1m_r) * segint_pkg::num_t'(d_dxm_r);
    e_py         = segint_pkg::num_t'(d_n1m_r) * segint_pkg::num_t'(d_dym_r);
    e_d_nxt.hit  = d_hit_r;
    e_d_nxt.negx = d_negx_r;
    e_d_nxt.negy = d_negy_r;
    e_d_nxt.d    = d_dnm_r;
    e_d_nxt.rx   = e_px[segint_pkg::NW-1:segint_pkg::CW];
    e_d_nxt.ry   = e_py[segint_pkg::NW-1:segint_pkg::CW];
    e_d_nxt.nx   = e_px[segint_pkg::CW-1:0];
    e_d_nxt.ny   = e_py[segint_pkg::CW-1:0];
    e_d_nxt.qx   = '0;
    e_d_nxt.qy   = '0;
    e_d_nxt.pts  = d_pts_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= in_vld;
      if (b_rdy) b_vld_r <= a_vld_r;
      if (c_rdy) c_vld_r <= b_vld_r;
      if (d_rdy) d_vld_r <= c_vld_r;
      if (e_rdy) e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_pts_r  <= a_pts_nxt;
      a_dx21_r <= a_dx21_nxt;
      a_dy21_r <= a_dy21_nxt;
      a_dx43_r <= a_dx43_nxt;
      a_dy43_r <= a_dy43_nxt;
      a_dx13_r <= a_dx13_nxt;
      a_dy13_r <= a_dy13_nxt;
    end
    if (b_rdy) begin
      b_pts_r  <= a_pts_r;
      b_dx21_r <= a_dx21_r;
      b_dy21_r <= a_dy21_r;
      b_p0_r   <= b_p0_nxt;
      b_p1_r   <= b_p1_nxt;
      b_p2_r   <= b_p2_nxt;
      b_p3_r   <= b_p3_nxt;
      b_p4_r   <= b_p4_nxt;
      b_p5_r   <= b_p5_nxt;
    end
    if (c_rdy) begin
      c_pts_r  <= b_pts_r;
      c_dx21_r <= b_dx21_r;
      c_dy21_r <= b_dy21_r;
      c_den_r  <= c_den_nxt;
      c_num1_r <= c_num1_nxt;
      c_num2_r <= c_num2_nxt;
    end
    if (d_rdy) begin
      d_pts_r  <= c_pts_r;
      d_hit_r  <= d_hit_nxt;
      d_negx_r <= d_negx_nxt;
      d_negy_r <= d_negy_nxt;
      d_n1m_r  <= d_n1m_nxt;
      d_dnm_r  <= d_dnm_nxt;
      d_dxm_r  <= dmag(c_dx21_r);
      d_dym_r  <= dmag(c_dy21_r);
    end
    if (e_rdy) begin
      e_d_r <= e_d_nxt;
    end
  end

  assign out_vld = e_vld_r;
  assign out_d   = e_d_r;

endmodule

// ----- rtl/segint_cell.sv -----
// One restoring-division cell: one quotient bit for the x and y lanes.
// Uses segint_pkg.
module segint_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_vld,
  output logic               up_rdy,
  input  segint_pkg::dcell_t up_d,
  output logic               dn_vld,
  input  logic               dn_rdy,
  output segint_pkg::dcell_t dn_d
);

  logic vld_r;
  segint_pkg::dcell_t d_r, d_nxt;
  logic [segint_pkg::DW:0] sx, sy, dd;
  logic gex, gey;

  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    dd    = {1'b0, up_d.d};
    sx    = {up_d.rx, up_d.nx[segint_pkg::CW-1]};
    sy    = {up_d.ry, up_d.ny[segint_pkg::CW-1]};
    gex   = sx >= dd;
    gey   = sy >= dd;
    d_nxt = up_d;
    d_nxt.rx = gex ? segint_pkg::mag_t'(sx - dd) : sx[segint_pkg::DW-1:0];
    d_nxt.ry = gey ? segint_pkg::mag_t'(sy - dd) : sy[segint_pkg::DW-1:0];
    d_nxt.nx = {up_d.nx[segint_pkg::CW-2:0], 1'b0};
    d_nxt.ny = {up_d.ny[segint_pkg::CW-2:0], 1'b0};
    d_nxt.qx = {up_d.qx[segint_pkg::CW-2:0], gex};
    d_nxt.qy = {up_d.qy[segint_pkg::CW-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      d_r <= d_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_d   = d_r;

endmodule

// ----- rtl/segint_back.sv -----
// Output stage: applies quotient signs, offsets from the first start point,
// rejects endpoint hits and holds the result item. Uses segint_pkg.
module segint_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_vld,
  output logic                 up_rdy,
  input  segint_pkg::dcell_t   up_d,
  output logic                 out_vld,
  input  logic                 out_stall,
  output segint_pkg::out_item_t out_d
);

  logic vld_r;
  segint_pkg::out_item_t d_r, d_nxt;
  segint_pkg::pos_t sqx, sqy, pxw, pyw;
  segint_pkg::coord_t px, py;
  logic on_end;

  assign up_rdy = !vld_r || !out_stall;

  always_comb begin
    sqx = segint_pkg::pos_t'({2'b00, up_d.qx});
    sqy = segint_pkg::pos_t'({2'b00, up_d.qy});
    pxw = segint_pkg::pos_t'($signed(up_d.pts.x1)) + (up_d.negx ? -sqx : sqx);
    pyw = segint_pkg::pos_t'($signed(up_d.pts.y1)) + (up_d.negy ? -sqy : sqy);
    px  = pxw[segint_pkg::CW-1:0];
    py  = pyw[segint_pkg::CW-1:0];
    on_end = (px == up_d.pts.x1 && py == up_d.pts.y1)
          || (px == up_d.pts.x2 && py == up_d.pts.y2)
          || (px == up_d.pts.x3 && py == up_d.pts.y3)
          || (px == up_d.pts.x4 && py == up_d.pts.y4);
    d_nxt = '0;
    if (up_d.hit && !on_end) begin
      d_nxt.crossing_found = 1'b1;
      d_nxt.cross_x        = px;
      d_nxt.cross_y        = py;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

// ----- rtl/segment_intersection_test_core.sv -----
// Segment crossing test: front pipeline, a row of divider cells, output stage.
// Uses segint_pkg, segint_front, segint_cell and segint_back.
// Pipeline: 5 front stages + CW divider cells (16) + 1 output stage.
// Throughput: one item per cycle while out_stall is low; each divider cell resolves one quotient bit.
// Stages only stall when their successor is full and stalled, so bubbles close.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module segment_intersection_test_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  segint_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output segint_pkg::out_item_t out_item
);

  logic               c_vld [segint_pkg::CW+1];
  logic               c_rdy [segint_pkg::CW+1];
  segint_pkg::dcell_t c_d   [segint_pkg::CW+1];
  logic               in_rdy;

  assign in_stall = !in_rdy;

  segint_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_valid),
    .in_rdy  (in_rdy),
    .in_d    (in_item),
    .out_vld (c_vld[0]),
    .out_rdy (c_rdy[0]),
    .out_d   (c_d[0])
  );

  for (genvar i = 0; i < segint_pkg::CW; i++) begin : g_cell
    segint_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .up_vld (c_vld[i]),
      .up_rdy (c_rdy[i]),
      .up_d   (c_d[i]),
      .dn_vld (c_vld[i+1]),
      .dn_rdy (c_rdy[i+1]),
      .dn_d   (c_d[i+1])
    );
  end

  segint_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_vld    (c_vld[segint_pkg::CW]),
    .up_rdy    (c_rdy[segint_pkg::CW]),
    .up_d      (c_d[segint_pkg::CW]),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_d     (out_item)
  );

endmodule
